[sv/kpc_pkg.sv]
// kpc_pkg: shared types and codes for the key press classifier
// no dependencies; used by the interfaces and by key_press_classifier
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // one-hot machine states
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONFIRM = 5'b00010,
        ST_SHORT   = 5'b00100,
        ST_LONG    = 5'b01000,
        ST_DOUBLE  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ON_RELEASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ON_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ON_RELEASE = 3'd6;

    typedef struct packed {
        logic              pressed_level;
        logic [CFG_W-1:0]  confirm_time;
        logic [CFG_W-1:0]  long_time;
        logic [CFG_W-1:0]  double_window;
        logic              short_on_release;
        logic              long_on_release;
        logic              double_on_release;
    } cfg_t;

endpackage

`default_nettype wire

[sv/kpc_if.sv]
// kpc_if: valid/ready channel interfaces for scan items and event results
// depends on kpc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kpc_scan_if;
    logic                         valid;
    logic                         ready;
    logic                         pin_level;
    logic [kpc_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface kpc_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

`default_nettype wire

[sv/key_press_classifier.sv]
// key_press_classifier: debounced short / long / double key press classifier
// Each accepted scan transaction yields exactly one event transaction carrying the
// sticky event register after the update. A scan is taken into an input register,
// and the state update runs from there into the state and result registers, so one
// scan is accepted every cycle unless evt.ready stalls the result register. The state
// update is combinational (a 32-bit subtract and compare per time check).
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while no scan is in flight, not enforced by the block; needs kpc_pkg, kpc_if.
`timescale 1ns / 1ps
`default_nettype none

module key_press_classifier (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    kpc_scan_if.sink                             scan,
    kpc_event_if.source                          evt,
    input  wire logic                            cfg_we,
    input  wire logic [kpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kpc_pkg::CFG_W-1:0]       cfg_data
);

    kpc_pkg::cfg_t   cfg_reg;

    logic                         in_valid_reg;
    logic                         in_level_reg;
    logic [kpc_pkg::TIME_W-1:0]   in_now_reg;

    kpc_pkg::state_t              state_reg,   state_next;
    kpc_pkg::event_t              event_reg,   event_next;
    logic [kpc_pkg::TIME_W-1:0]   press_start_reg,  press_start_next;
    logic [kpc_pkg::TIME_W-1:0]   release_time_reg, release_time_next;
    logic                         click_reg,   click_next;
    logic                         out_valid_reg;

    logic                         advance;
    logic                         pressed;
    logic [kpc_pkg::TIME_W-1:0]   dur;
    logic [kpc_pkg::TIME_W-1:0]   gap;
    logic                         expired;
    logic                         click_eff;
    logic [kpc_pkg::TIME_W-1:0]   release_eff;
    logic [kpc_pkg::TIME_W-1:0]   confirm_ext;
    logic [kpc_pkg::TIME_W-1:0]   long_ext;
    logic [kpc_pkg::TIME_W-1:0]   window_ext;

    // update stage fires when the result register is free or being drained
    assign advance    = in_valid_reg && (!out_valid_reg || evt.ready);
    assign scan.ready = !in_valid_reg || advance;
    assign evt.valid  = out_valid_reg;
    assign evt.event_res = event_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressed_level     <= 1'b0;
            cfg_reg.confirm_time      <= 16'd20;
            cfg_reg.long_time         <= 16'd1000;
            cfg_reg.double_window     <= 16'd300;
            cfg_reg.short_on_release  <= 1'b0;
            cfg_reg.long_on_release   <= 1'b0;
            cfg_reg.double_on_release <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpc_pkg::REG_PRESSED_LEVEL:     cfg_reg.pressed_level     <= cfg_data[0];
                kpc_pkg::REG_CONFIRM_TIME:      cfg_reg.confirm_time      <= cfg_data;
                kpc_pkg::REG_LONG_TIME:         cfg_reg.long_time         <= cfg_data;
                kpc_pkg::REG_DOUBLE_WINDOW:     cfg_reg.double_window     <= cfg_data;
                kpc_pkg::REG_SHORT_ON_RELEASE:  cfg_reg.short_on_release  <= cfg_data[0];
                kpc_pkg::REG_LONG_ON_RELEASE:   cfg_reg.long_on_release   <= cfg_data[0];
                kpc_pkg::REG_DOUBLE_ON_RELEASE: cfg_reg.double_on_release <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scan.ready)
        begin
            in_valid_reg <= scan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            in_level_reg <= scan.pin_level;
            in_now_reg   <= scan.now_ms;
        end
    end

    assign confirm_ext = {{(kpc_pkg::TIME_W-kpc_pkg::CFG_W){1'b0}}, cfg_reg.confirm_time};
    assign long_ext    = {{(kpc_pkg::TIME_W-kpc_pkg::CFG_W){1'b0}}, cfg_reg.long_time};
    assign window_ext  = {{(kpc_pkg::TIME_W-kpc_pkg::CFG_W){1'b0}}, cfg_reg.double_window};

    assign pressed = (in_level_reg == cfg_reg.pressed_level);
    assign dur     = in_now_reg - press_start_reg;
    assign gap     = in_now_reg - release_time_reg;

    // double window expiry happens before the state update
    assign expired     = click_reg && (gap > window_ext);
    assign click_eff   = expired ? 1'b0 : click_reg;
    assign release_eff = expired ? '0 : release_time_reg;

    always_comb
    begin
        state_next        = state_reg;
        event_next        = event_reg;
        press_start_next  = press_start_reg;
        release_time_next = release_eff;
        click_next        = click_eff;
        case (state_reg)
            kpc_pkg::ST_IDLE:
            begin
                if (pressed)
                begin
                    state_next       = kpc_pkg::ST_CONFIRM;
                    press_start_next = in_now_reg;
                end
                else
                begin
                    event_next = kpc_pkg::EV_NONE;
                end
            end
            kpc_pkg::ST_CONFIRM:
            begin
                if (pressed)
                begin
                    if (dur > confirm_ext)
                    begin
                        state_next = kpc_pkg::ST_SHORT;
                        if (!cfg_reg.short_on_release)
                            event_next = kpc_pkg::EV_SHORT;
                    end
                end
                else
                begin
                    state_next = kpc_pkg::ST_IDLE;
                end
            end
            kpc_pkg::ST_SHORT:
            begin
                if (pressed)
                begin
                    if (dur > long_ext)
                    begin
                        state_next = kpc_pkg::ST_LONG;
                        if (!cfg_reg.long_on_release)
                            event_next = kpc_pkg::EV_LONG;
                    end
                end
                else if (dur <= window_ext && !click_eff)
                begin
                    // first click: open the double window
                    click_next        = 1'b1;
                    release_time_next = in_now_reg;
                    state_next        = kpc_pkg::ST_IDLE;
                    if (cfg_reg.short_on_release)
                        event_next = kpc_pkg::EV_SHORT;
                end
                else if (click_eff)
                begin
                    state_next = kpc_pkg::ST_DOUBLE;
                    if (!cfg_reg.double_on_release)
                        event_next = kpc_pkg::EV_DOUBLE;
                end
                else
                begin
                    // too long for a first click, no earlier click pending
                    state_next = kpc_pkg::ST_IDLE;
                    if (cfg_reg.short_on_release)
                        event_next = kpc_pkg::EV_SHORT;
                end
            end
            kpc_pkg::ST_DOUBLE:
            begin
                if (!pressed)
                begin
                    click_next = 1'b0;
                    state_next = kpc_pkg::ST_IDLE;
                    if (cfg_reg.double_on_release)
                        event_next = kpc_pkg::EV_DOUBLE;
                end
            end
            kpc_pkg::ST_LONG:
            begin
                if (!pressed)
                begin
                    state_next = kpc_pkg::ST_IDLE;
                    if (cfg_reg.long_on_release)
                        event_next = kpc_pkg::EV_LONG;
                end
            end
            default:
            begin
                state_next = kpc_pkg::ST_IDLE;
                event_next = kpc_pkg::EV_NONE;
            end
        endcase
    end

    // state and result registers; event_reg doubles as the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kpc_pkg::ST_IDLE;
            event_reg        <= kpc_pkg::EV_NONE;
            press_start_reg  <= '0;
            release_time_reg <= '0;
            click_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg        <= state_next;
                event_reg        <= event_next;
                press_start_reg  <= press_start_next;
                release_time_reg <= release_time_next;
                click_reg        <= click_next;
                out_valid_reg    <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // every update produces a result transaction
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("update without result");

    // the event register only moves when a scan is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(event_reg) && $stable(state_reg))
        else $error("state changed without a scan");

    // released key in idle clears the sticky event
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg == kpc_pkg::ST_IDLE && !pressed
        |=> event_reg == kpc_pkg::EV_NONE)
        else $error("event not cleared in idle");

    // a stalled result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !evt.ready |=> out_valid_reg && $stable(event_reg))
        else $error("pending result lost");

endmodule

`default_nettype wire
